// File: hw/rtl/vector_matrix_transform_macros.svh
// Assertion macros used by the vector matrix transform top level.
`ifndef VECTOR_MATRIX_TRANSFORM_MACROS_SVH
`define VECTOR_MATRIX_TRANSFORM_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define VMT_ASSERT_IMP(label, clk_s, rst_s, pre, post) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (pre) |-> (post)) \
    else $error("vector_matrix_transform: assertion failed");

// Next-cycle implication, disabled during reset.
`define VMT_ASSERT_NXT(label, clk_s, rst_s, pre, post) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (pre) |=> (post)) \
    else $error("vector_matrix_transform: assertion failed");

`endif

// File: hw/rtl/vmt_pkg.sv
// Package with the constants and types of the vector matrix transform.
`default_nettype none

package vmt_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = 4;
  localparam int DIM       = 4;
  localparam int ELEMS     = DIM * DIM;
  localparam int COMPS     = 3;
  localparam int LIMIT_W   = 17;

  // Widths of the accumulation and division datapath.
  localparam int PROD_W = 2 * DATA_W;
  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W  = PROD_W + 2;
  localparam int ACC_W  = SUM_W - FRAC_BITS;
  localparam int MAG_W  = ACC_W;
  localparam int QUO_W  = DATA_W + FRAC_BITS + 1;

  // Output queue sized to cover every result that can be in flight.
  localparam int PIPE_LAT   = QUO_W + 10;
  localparam int FIFO_AW    = $clog2(PIPE_LAT + 2);
  localparam int FIFO_DEPTH = 1 << FIFO_AW;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(66);
  localparam logic [DATA_W-1:0]  FIX_ONE     = DATA_W'(1) << FRAC_BITS;
  localparam logic [DATA_W-1:0]  SAT_MAX     = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0]  SAT_MIN     = {1'b1, {(DATA_W-1){1'b0}}};

  // Request codes.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_XFORM = 1'b1;

  typedef logic signed [DATA_W-1:0] data_t;

  // One finished result.
  typedef struct packed {
    logic [DATA_W-1:0] out_x;
    logic [DATA_W-1:0] out_y;
    logic [DATA_W-1:0] out_z;
    logic              divided;
    logic              saturated;
  } res_t;

  // Contents of one divider stage.
  typedef struct packed {
    logic                         valid;
    logic                         div;
    logic [COMPS-1:0]             neg;
    logic [COMPS-1:0]             ovf;
    logic [MAG_W-1:0]             den;
    logic [COMPS-1:0][QUO_W-1:0]  nq;
    logic [COMPS-1:0][MAG_W-1:0]  rem;
    logic [COMPS-1:0][DATA_W-1:0] plain;
    logic                         plain_sat;
  } div_stage_t;

endpackage

`default_nettype wire

// File: hw/rtl/vmt_req_if.sv
// Request channel interface: matrix loads and vector transforms.
`default_nettype none

interface vmt_req_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [vmt_pkg::IDX_W-1:0]    elem_index;
  logic signed [vmt_pkg::DATA_W-1:0] elem_value;
  logic signed [vmt_pkg::DATA_W-1:0] vec_x;
  logic signed [vmt_pkg::DATA_W-1:0] vec_y;
  logic signed [vmt_pkg::DATA_W-1:0] vec_z;
  logic signed [vmt_pkg::DATA_W-1:0] vec_w;
  logic                         persp_divide;

  modport source (
    output valid, req_type, elem_index, elem_value, vec_x, vec_y, vec_z, vec_w,
           persp_divide,
    input  ready
  );
  modport sink (
    input  valid, req_type, elem_index, elem_value, vec_x, vec_y, vec_z, vec_w,
           persp_divide,
    output ready
  );
endinterface

`default_nettype wire

// File: hw/rtl/vmt_res_if.sv
// Result channel interface: transformed vectors.
`default_nettype none

interface vmt_res_if;
  logic                         valid;
  logic                         ready;
  logic signed [vmt_pkg::DATA_W-1:0] out_x;
  logic signed [vmt_pkg::DATA_W-1:0] out_y;
  logic signed [vmt_pkg::DATA_W-1:0] out_z;
  logic                         divided;
  logic                         saturated;

  modport source (
    output valid, out_x, out_y, out_z, divided, saturated,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, divided, saturated,
    output ready
  );
endinterface

`default_nettype wire

// File: hw/rtl/vmt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module vmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/vmt_out_fifo.sv
// Result queue: RAM storage whose read register drives the result channel.
`default_nettype none

module vmt_out_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  vmt_pkg::res_t wdata,
  output logic          out_valid,
  input  logic          out_ready,
  output vmt_pkg::res_t out_data
);

  logic [vmt_pkg::FIFO_AW:0] wptr;
  logic [vmt_pkg::FIFO_AW:0] rptr;
  logic [vmt_pkg::FIFO_AW:0] used;
  logic                      re;
  logic [$bits(vmt_pkg::res_t)-1:0] rdata;

  // Entries in RAM not yet moved to the read register.
  assign used = wptr - rptr;
  assign re   = (used != '0) && (!out_valid || out_ready);

  vmt_ram #(
    .WIDTH ($bits(vmt_pkg::res_t)),
    .DEPTH (vmt_pkg::FIFO_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (push),
    .waddr (wptr[vmt_pkg::FIFO_AW-1:0]),
    .wdata (wdata),
    .re    (re),
    .raddr (rptr[vmt_pkg::FIFO_AW-1:0]),
    .rdata (rdata)
  );

  assign out_data = vmt_pkg::res_t'(rdata);

  // Pointers and the valid flag of the read register.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr      <= '0;
      rptr      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (re) begin
        rptr      <= rptr + 1'b1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/vmt_divider.sv
// Pipelined restoring divider for the perspective divide, one quotient bit per stage.
`default_nettype none

module vmt_divider (
  input  logic                clk,
  input  logic                rst,
  input  vmt_pkg::div_stage_t din,
  output logic                push,
  output vmt_pkg::res_t       dout
);

  localparam logic [vmt_pkg::QUO_W-1:0] M_LIM =
    vmt_pkg::QUO_W'(1) << (vmt_pkg::DATA_W - 1);

  vmt_pkg::div_stage_t st [vmt_pkg::QUO_W+1];
  vmt_pkg::div_stage_t fin;
  vmt_pkg::div_stage_t fin_next;

  // Entry register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st[0].valid <= 1'b0;
    end else begin
      st[0] <= din;
    end
  end

  // Each stage shifts one dividend bit into the remainder and one quotient bit in.
  for (genvar k = 0; k < vmt_pkg::QUO_W; k++) begin : g_step
    vmt_pkg::div_stage_t st_next;

    always_comb begin
      logic [vmt_pkg::MAG_W:0]   r2;
      logic [vmt_pkg::MAG_W+1:0] diff;
      st_next = st[k];
      for (int l = 0; l < vmt_pkg::COMPS; l++) begin
        r2   = {st[k].rem[l], st[k].nq[l][vmt_pkg::QUO_W-1]};
        diff = {1'b0, r2} - {2'b00, st[k].den};
        if (!diff[vmt_pkg::MAG_W+1]) begin
          st_next.rem[l] = diff[vmt_pkg::MAG_W-1:0];
          st_next.nq[l]  = {st[k].nq[l][vmt_pkg::QUO_W-2:0], 1'b1};
        end else begin
          st_next.rem[l] = r2[vmt_pkg::MAG_W-1:0];
          st_next.nq[l]  = {st[k].nq[l][vmt_pkg::QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st[k+1].valid <= 1'b0;
      end else begin
        st[k+1] <= st_next;
      end
    end
  end

  // Round the quotient magnitude to nearest, ties away from zero.
  always_comb begin
    logic [vmt_pkg::QUO_W:0] inc;
    fin_next = st[vmt_pkg::QUO_W];
    for (int l = 0; l < vmt_pkg::COMPS; l++) begin
      inc             = {1'b0, st[vmt_pkg::QUO_W].nq[l]} + 1'b1;
      fin_next.nq[l]  = inc[vmt_pkg::QUO_W:1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin.valid <= 1'b0;
    end else begin
      fin <= fin_next;
    end
  end

  // Apply the sign, saturate, and choose between divided and plain results.
  logic [vmt_pkg::COMPS-1:0][vmt_pkg::DATA_W-1:0] val;
  logic [vmt_pkg::COMPS-1:0]                      lane_sat;

  always_comb begin
    for (int l = 0; l < vmt_pkg::COMPS; l++) begin
      lane_sat[l] = 1'b0;
      if (!fin.div) begin
        val[l] = fin.plain[l];
      end else if (fin.ovf[l]) begin
        lane_sat[l] = 1'b1;
        val[l]      = fin.neg[l] ? vmt_pkg::SAT_MIN : vmt_pkg::SAT_MAX;
      end else if (fin.neg[l]) begin
        if (fin.nq[l] > M_LIM) begin
          lane_sat[l] = 1'b1;
          val[l]      = vmt_pkg::SAT_MIN;
        end else begin
          val[l] = ~fin.nq[l][vmt_pkg::DATA_W-1:0] + 1'b1;
        end
      end else begin
        if (fin.nq[l] >= M_LIM) begin
          lane_sat[l] = 1'b1;
          val[l]      = vmt_pkg::SAT_MAX;
        end else begin
          val[l] = fin.nq[l][vmt_pkg::DATA_W-1:0];
        end
      end
    end
  end

  // Output register feeding the result queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      push <= fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    dout.out_x     <= val[0];
    dout.out_y     <= val[1];
    dout.out_z     <= val[2];
    dout.divided   <= fin.div;
    dout.saturated <= fin.div ? (|lane_sat) : fin.plain_sat;
  end

endmodule

`default_nettype wire

// File: hw/rtl/vector_matrix_transform.sv
// Top level of the 4x4 homogeneous vertex transform with perspective divide.
// Usage:
// - The req channel carries one transaction per item. A load transaction
//   (req_type 0) writes one Q16.16 matrix element at row*4+column and gives
//   no result; a transform transaction (req_type 1) multiplies the row
//   vector (x, y, z, w) by the matrix and gives one result on res.
// - With persp_divide set and |w'| above near_zero_limit, x', y' and z' are
//   divided by w'; divided reports it, saturated reports any clipping.
// - cfg_we/cfg_wdata write near_zero_limit; write only while the block idles.
// - A new transaction is taken every cycle while req.ready is high. A transform
//   result passes through five multiply and accumulate stages, the divider
//   entry stage, one divider stage per quotient bit (with one extra bit for
//   rounding the Q16.16 result), the rounding and output stages, then the
//   result queue write and its read register.
// - Reset restores the identity matrix and a limit of 66, and drops all
//   results in flight.
// - When res stalls, results collect in a queue that holds every result in
//   flight; req.ready falls only when that queue could fill up.
`default_nettype none

`include "vector_matrix_transform_macros.svh"

module vector_matrix_transform (
  input  logic                         clk,
  input  logic                         rst,
  vmt_req_if.sink                      req,
  vmt_res_if.source                    res,
  input  logic                         cfg_we,
  input  logic [vmt_pkg::LIMIT_W-1:0]  cfg_wdata
);

  logic [vmt_pkg::LIMIT_W-1:0] limit;
  vmt_pkg::data_t              matrix [vmt_pkg::ELEMS];
  logic [vmt_pkg::FIFO_AW:0]   cnt;
  logic                        req_acc;
  logic                        load_acc;
  logic                        xform_acc;
  logic                        res_acc;

  assign req_acc   = req.valid && req.ready;
  assign load_acc  = req_acc && (req.req_type == vmt_pkg::REQ_LOAD);
  assign xform_acc = req_acc && (req.req_type == vmt_pkg::REQ_XFORM);
  assign res_acc   = res.valid && res.ready;
  assign req.ready = (cnt != (vmt_pkg::FIFO_AW+1)'(vmt_pkg::FIFO_DEPTH));

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= vmt_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      limit <= cfg_wdata;
    end
  end

  // Matrix store; a load transaction writes one element.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < vmt_pkg::DIM; r++) begin
        for (int c = 0; c < vmt_pkg::DIM; c++) begin
          matrix[r * vmt_pkg::DIM + c] <= (r == c) ? vmt_pkg::FIX_ONE : '0;
        end
      end
    end else if (load_acc) begin
      matrix[req.elem_index] <= req.elem_value;
    end
  end

  // Results accepted but not yet delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt + (vmt_pkg::FIFO_AW+1)'(xform_acc) - (vmt_pkg::FIFO_AW+1)'(res_acc);
    end
  end

  // Stage 1: capture the vector.
  logic           s1_valid;
  logic           s1_pd;
  vmt_pkg::data_t s1_v [vmt_pkg::DIM];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= xform_acc;
    end
  end

  always_ff @(posedge clk) begin
    s1_pd   <= req.persp_divide;
    s1_v[0] <= req.vec_x;
    s1_v[1] <= req.vec_y;
    s1_v[2] <= req.vec_z;
    s1_v[3] <= req.vec_w;
  end

  // Stage 2: sixteen products.
  logic                              s2_valid;
  logic                              s2_pd;
  logic signed [vmt_pkg::PROD_W-1:0] s2_prod [vmt_pkg::DIM][vmt_pkg::DIM];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_pd <= s1_pd;
    for (int r = 0; r < vmt_pkg::DIM; r++) begin
      for (int c = 0; c < vmt_pkg::DIM; c++) begin
        s2_prod[r][c] <= s1_v[r] * matrix[r * vmt_pkg::DIM + c];
      end
    end
  end

  // Stage 3: pairwise sums per column.
  logic                              s3_valid;
  logic                              s3_pd;
  logic signed [vmt_pkg::PAIR_W-1:0] s3_pair [vmt_pkg::DIM][2];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_pd <= s2_pd;
    for (int c = 0; c < vmt_pkg::DIM; c++) begin
      for (int h = 0; h < 2; h++) begin
        s3_pair[c][h] <= vmt_pkg::PAIR_W'(s2_prod[2*h][c]) +
                         vmt_pkg::PAIR_W'(s2_prod[2*h+1][c]);
      end
    end
  end

  // Stage 4: full sum, rounded to nearest with ties upward.
  localparam logic signed [vmt_pkg::SUM_W-1:0] HALF =
    vmt_pkg::SUM_W'(1) << (vmt_pkg::FRAC_BITS - 1);

  logic                             s4_valid;
  logic                             s4_pd;
  logic signed [vmt_pkg::ACC_W-1:0] s4_acc [vmt_pkg::DIM];
  logic signed [vmt_pkg::SUM_W-1:0] col_sum [vmt_pkg::DIM];

  always_comb begin
    for (int c = 0; c < vmt_pkg::DIM; c++) begin
      col_sum[c] = vmt_pkg::SUM_W'(s3_pair[c][0]) + vmt_pkg::SUM_W'(s3_pair[c][1]) + HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    s4_pd <= s3_pd;
    for (int c = 0; c < vmt_pkg::DIM; c++) begin
      s4_acc[c] <= col_sum[c][vmt_pkg::SUM_W-1:vmt_pkg::FRAC_BITS];
    end
  end

  // Stage 5: magnitudes, quotient signs and the undivided saturated results.
  logic                                            s5_valid;
  logic                                            s5_pd;
  logic [vmt_pkg::COMPS-1:0][vmt_pkg::MAG_W-1:0]   s5_ua;
  logic [vmt_pkg::MAG_W-1:0]                       s5_uw;
  logic [vmt_pkg::COMPS-1:0]                       s5_neg;
  logic [vmt_pkg::COMPS-1:0][vmt_pkg::DATA_W-1:0]  s5_plain;
  logic                                            s5_plain_sat;
  logic [vmt_pkg::COMPS-1:0]                       in_range;

  always_comb begin
    for (int l = 0; l < vmt_pkg::COMPS; l++) begin
      in_range[l] = (&s4_acc[l][vmt_pkg::ACC_W-1:vmt_pkg::DATA_W-1]) ||
                    !(|s4_acc[l][vmt_pkg::ACC_W-1:vmt_pkg::DATA_W-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    s5_pd        <= s4_pd;
    s5_uw        <= s4_acc[3][vmt_pkg::ACC_W-1] ? (~s4_acc[3] + 1'b1) : s4_acc[3];
    s5_plain_sat <= !(&in_range);
    for (int l = 0; l < vmt_pkg::COMPS; l++) begin
      s5_ua[l]  <= s4_acc[l][vmt_pkg::ACC_W-1] ? (~s4_acc[l] + 1'b1) : s4_acc[l];
      s5_neg[l] <= s4_acc[l][vmt_pkg::ACC_W-1] ^ s4_acc[3][vmt_pkg::ACC_W-1];
      if (in_range[l]) begin
        s5_plain[l] <= s4_acc[l][vmt_pkg::DATA_W-1:0];
      end else begin
        s5_plain[l] <= s4_acc[l][vmt_pkg::ACC_W-1] ? vmt_pkg::SAT_MIN : vmt_pkg::SAT_MAX;
      end
    end
  end

  // Near-zero test, quotient overflow test and divider start values.
  vmt_pkg::div_stage_t din;

  always_comb begin
    din.valid     = s5_valid;
    din.div       = s5_pd && (s5_uw > vmt_pkg::MAG_W'(limit));
    din.neg       = s5_neg;
    din.den       = s5_uw;
    din.plain     = s5_plain;
    din.plain_sat = s5_plain_sat;
    for (int l = 0; l < vmt_pkg::COMPS; l++) begin
      din.rem[l] = s5_ua[l] >> vmt_pkg::DATA_W;
      din.ovf[l] = (s5_ua[l] >> vmt_pkg::DATA_W) >= s5_uw;
      din.nq[l]  = {s5_ua[l][vmt_pkg::DATA_W-1:0], {(vmt_pkg::FRAC_BITS+1){1'b0}}};
    end
  end

  logic          push;
  vmt_pkg::res_t div_res;
  vmt_pkg::res_t q_res;

  vmt_divider u_divider (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .push (push),
    .dout (div_res)
  );

  vmt_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wdata     (div_res),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_data  (q_res)
  );

  assign res.out_x     = q_res.out_x;
  assign res.out_y     = q_res.out_y;
  assign res.out_z     = q_res.out_z;
  assign res.divided   = q_res.divided;
  assign res.saturated = q_res.saturated;

  // Checks on the result accounting and the matrix store.
  `VMT_ASSERT_IMP(a_cnt_bound, clk, rst, 1'b1, cnt <= (vmt_pkg::FIFO_AW+1)'(vmt_pkg::FIFO_DEPTH))
  `VMT_ASSERT_IMP(a_no_phantom, clk, rst, cnt == '0, !res.valid)
  `VMT_ASSERT_NXT(a_load, clk, rst, load_acc, matrix[$past(req.elem_index)] == $past(req.elem_value))

endmodule

`default_nettype wire

// File: sim/vector_matrix_transform_test.sv
// Self-checking testbench for the 4x4 vertex transform with perspective divide.
`timescale 1ns / 100ps

module vector_matrix_transform_test;
  import vmt_pkg::*;

  typedef logic signed [71:0] wide_t;

  // Predicts transform results and matches them against the result channel.
  class transform_scoreboard;
    data_t            matrix[ELEMS];
    logic [LIMIT_W-1:0] limit;
    res_t             expected_q[$];
    int               errors;

    function new();
      for (int i = 0; i < ELEMS; i++) begin
        matrix[i] = (i % 5 == 0) ? data_t'(FIX_ONE) : '0;
      end
      limit = LIMIT_RESET;
      errors = 0;
    endfunction

    function void set_limit(logic [LIMIT_W-1:0] value);
      limit = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("%0t mismatch on %s: got %h expected %h", $realtime, what, got, want);
    endtask

    // Exact column sum, rounded to FRAC_BITS with ties toward plus infinity.
    function wide_t column_sum(data_t v[DIM], int col);
      wide_t sum;
      longint p;
      sum = '0;
      for (int r = 0; r < DIM; r++) begin
        p = longint'(v[r]) * longint'(matrix[r * DIM + col]);
        sum += 72'(p);
      end
      return (sum + (72'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function logic [31:0] clip(wide_t a, inout bit sat);
      if (a > 72'sd2147483647) begin
        sat = 1;
        return SAT_MAX;
      end
      if (a < -72'sd2147483648) begin
        sat = 1;
        return SAT_MIN;
      end
      return a[31:0];
    endfunction

    // Full-precision quotient, magnitude rounded half away from zero.
    function logic [31:0] divide_fix(wide_t a, wide_t w, inout bit sat);
      logic [71:0] ua, uw;
      logic [99:0] q, m, t;
      bit neg;
      ua = (a < 0) ? -a : a;
      uw = (w < 0) ? -w : w;
      neg = (a < 0) != (w < 0);
      q = ({28'b0, ua} << (FRAC_BITS + 1)) / {28'b0, uw};
      m = (q + 1) >> 1;
      if (neg) begin
        if (m > 100'h80000000) begin
          sat = 1;
          return SAT_MIN;
        end
        t = -m;
        return t[31:0];
      end
      if (m > 100'h7fffffff) begin
        sat = 1;
        return SAT_MAX;
      end
      return m[31:0];
    endfunction

    function void note_request(logic rt, logic [IDX_W-1:0] idx, data_t val,
                               data_t x, data_t y, data_t z, data_t w, logic pd);
      data_t v[DIM];
      wide_t acc[DIM];
      wide_t mag_w;
      wide_t lim_w;
      logic [31:0] comp[COMPS];
      bit sat, div;
      res_t r;
      if (rt == REQ_LOAD) begin
        matrix[idx] = val;
        return;
      end
      v[0] = x; v[1] = y; v[2] = z; v[3] = w;
      for (int c = 0; c < DIM; c++) acc[c] = column_sum(v, c);
      mag_w = (acc[3] < 0) ? -acc[3] : acc[3];
      lim_w = {55'b0, limit};
      div = pd && (mag_w > lim_w);
      sat = 0;
      for (int c = 0; c < COMPS; c++) begin
        comp[c] = div ? divide_fix(acc[c], acc[3], sat) : clip(acc[c], sat);
      end
      r.out_x = comp[0];
      r.out_y = comp[1];
      r.out_z = comp[2];
      r.divided = div;
      r.saturated = sat;
      expected_q.push_back(r);
    endfunction

    task check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", got.out_x, '0);
        return;
      end
      want = expected_q.pop_front();
      if (got.out_x !== want.out_x) report_mismatch("out_x", got.out_x, want.out_x);
      if (got.out_y !== want.out_y) report_mismatch("out_y", got.out_y, want.out_y);
      if (got.out_z !== want.out_z) report_mismatch("out_z", got.out_z, want.out_z);
      if (got.divided !== want.divided)
        report_mismatch("divided", 32'(got.divided), 32'(want.divided));
      if (got.saturated !== want.saturated)
        report_mismatch("saturated", 32'(got.saturated), 32'(want.saturated));
    endtask
  endclass

  localparam int CYCLE_LIMIT = 800000;
  localparam int DRAIN_WAIT  = 80;
  localparam int LONG_HOLD   = 400;

  logic clk = 0;
  logic rst;
  logic cfg_we;
  logic [LIMIT_W-1:0] cfg_wdata;
  int cycles = 0;
  bit burst_mode = 0;
  bit hold_req = 0;
  transform_scoreboard sb = new();

  vmt_req_if req();
  vmt_res_if res();

  vector_matrix_transform dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .res(res),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int draw_gap();
    return burst_mode ? 0 : $urandom_range(0, 13);
  endfunction

  // Mix of full-range, extreme, tiny and moderate Q16.16 values.
  function automatic data_t rand_value();
    case ($urandom_range(0, 11))
      0: return data_t'($urandom);
      1: begin
        case ($urandom_range(0, 4))
          0: return data_t'(SAT_MAX);
          1: return data_t'(SAT_MIN);
          2: return '0;
          3: return data_t'(FIX_ONE);
          default: return -data_t'(FIX_ONE);
        endcase
      end
      2: return data_t'($urandom_range(0, 400)) - 200;
      default: return data_t'($urandom_range(0, 1 << 20)) - (1 << 19);
    endcase
  endfunction

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    res.ready = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      int gap;
      if (hold_req) begin
        res.ready = 0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 0;
      end
      gap = draw_gap();
      res.ready = (gap == 0);
      repeat (gap) @(negedge clk);
      res.ready = 1;
      do @(posedge clk); while (!res.valid);
      sb.check_result('{res.out_x, res.out_y, res.out_z, res.divided, res.saturated});
      @(negedge clk);
    end
  end

  task automatic send_req(logic rt, logic [IDX_W-1:0] idx, data_t val,
                          data_t x, data_t y, data_t z, data_t w, logic pd);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      req.valid = 0;
      repeat (gap) @(negedge clk);
    end
    req.valid = 1;
    req.req_type = rt;
    req.elem_index = idx;
    req.elem_value = val;
    req.vec_x = x;
    req.vec_y = y;
    req.vec_z = z;
    req.vec_w = w;
    req.persp_divide = pd;
    do @(posedge clk); while (!req.ready);
    sb.note_request(rt, idx, val, x, y, z, w, pd);
    @(negedge clk);
  endtask

  // Load carries random noise in the vector fields, which the block ignores.
  task automatic load_elem(int idx, data_t val);
    send_req(REQ_LOAD, IDX_W'(idx), val, data_t'($urandom), data_t'($urandom),
             data_t'($urandom), data_t'($urandom), $urandom_range(0, 1));
  endtask

  task automatic xform(data_t x, data_t y, data_t z, data_t w, logic pd);
    send_req(REQ_XFORM, IDX_W'($urandom), data_t'($urandom), x, y, z, w, pd);
  endtask

  task automatic wait_drained();
    req.valid = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] value);
    wait_drained();
    cfg_we = 1;
    cfg_wdata = value;
    sb.set_limit(value);
    @(negedge clk);
    cfg_we = 0;
  endtask

  // Random matrix, sometimes projective so w' tracks z.
  task automatic load_matrix();
    bit proj;
    proj = ($urandom_range(0, 2) == 0);
    for (int i = 0; i < ELEMS; i++) begin
      if (proj && (i % DIM == 3))
        load_elem(i, (i == 11) ? data_t'(FIX_ONE) : data_t'($urandom_range(0, 64)) - 32);
      else
        load_elem(i, rand_value());
    end
  endtask

  task automatic random_phase(int count);
    int sent;
    int n;
    sent = 0;
    while (sent < count) begin
      burst_mode = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 5))
        0: load_matrix();
        1: begin
          n = $urandom_range(1, 4);
          repeat (n) load_elem($urandom_range(0, 15), rand_value());
        end
        default: begin
          n = $urandom_range(1, 20);
          repeat (n) begin
            xform(rand_value(), rand_value(), rand_value(),
                  ($urandom_range(0, 2) == 0) ? data_t'(FIX_ONE) : rand_value(),
                  $urandom_range(0, 1));
          end
          sent += n;
        end
      endcase
    end
    burst_mode = 0;
  endtask

  initial begin
    rst = 1;
    cfg_we = 0;
    cfg_wdata = '0;
    req.valid = 0;
    req.req_type = REQ_LOAD;
    req.elem_index = '0;
    req.elem_value = '0;
    req.vec_x = '0;
    req.vec_y = '0;
    req.vec_z = '0;
    req.vec_w = '0;
    req.persp_divide = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Identity matrix: extremes, divide by one, w' zero, at and just over the limit.
    xform(data_t'(SAT_MAX), data_t'(SAT_MIN), '0, data_t'(FIX_ONE), 0);
    xform(data_t'(SAT_MAX), data_t'(SAT_MIN), -1, data_t'(FIX_ONE), 1);
    xform(data_t'(FIX_ONE), 5, -7, '0, 1);
    xform(data_t'(FIX_ONE), 5, -7, 66, 1);
    xform(data_t'(FIX_ONE), -data_t'(FIX_ONE), 3, 67, 1);
    xform(data_t'(FIX_ONE), -data_t'(FIX_ONE), 3, -67, 1);
    // Extreme elements overflow the accumulation.
    load_elem(0, data_t'(SAT_MAX));
    load_elem(5, data_t'(SAT_MIN));
    load_elem(15, '0);
    load_elem(12, data_t'(SAT_MAX));
    xform(data_t'(SAT_MAX), data_t'(SAT_MAX), data_t'(SAT_MIN), data_t'(SAT_MIN), 0);
    xform(data_t'(SAT_MIN), data_t'(SAT_MIN), data_t'(SAT_MAX), data_t'(SAT_MAX), 1);
    load_elem(15, data_t'(FIX_ONE));
    load_elem(12, '0);
    load_elem(0, data_t'(FIX_ONE));
    load_elem(5, data_t'(FIX_ONE));
    xform(32'sh0000_8000, -32'sh0000_8000, 32'sh0000_0001, data_t'(FIX_ONE) * 2, 1);

    // Limit zero: only an exact zero w' skips the divide.
    write_limit('0);
    xform(data_t'(FIX_ONE), 7, -9, '0, 1);
    xform(data_t'(FIX_ONE), 7, -9, 1, 1);
    xform(data_t'(FIX_ONE), 7, -9, -1, 1);
    // Long receiver hold while the sender keeps offering transforms.
    hold_req = 1;
    burst_mode = 1;
    repeat (150) xform(rand_value(), rand_value(), rand_value(), data_t'(FIX_ONE), 1);
    burst_mode = 0;
    random_phase(250);

    // Limit of 1.0: w' of exactly 1.0 is still treated as zero.
    write_limit(LIMIT_W'(65536));
    xform(data_t'(FIX_ONE), 7, -9, data_t'(FIX_ONE), 1);
    xform(data_t'(FIX_ONE), 7, -9, data_t'(FIX_ONE) + 1, 1);
    random_phase(130);
    // Sender pause until the pipeline has emptied.
    wait_drained();
    random_phase(130);

    write_limit(LIMIT_W'($urandom_range(0, 65536)));
    random_phase(270);
    write_limit(LIMIT_RESET);
    random_phase(270);

    wait_drained();
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
